// ===== design/mvm_pkg.sv =====
// Shared types and constants for the matrix-vector multiply unit.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

    // Parameter defaults
    localparam int MVM_MAX_DIM   = 64;
    localparam int MVM_ACC_WIDTH = 40;

    // Fixed field widths
    localparam int MVM_DIM_CAP   = 64;   // hard ceiling on rows/columns
    localparam int DIM_W         = 7;    // dimension registers and position counters
    localparam int VALUE_W       = 16;   // Q8.8 values
    localparam int INDEX_W       = 6;    // result_index width
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 7;

    // Q16.16 -> Q8.8 conversion limits
    localparam int MVM_SAT_HI    = 8388480;    // at or above: clamp high
    localparam int MVM_SAT_LO    = -8388736;   // below: clamp low
    localparam int MVM_RND_BIAS  = 128;        // half an output LSB
    localparam int MVM_FRAC_DROP = 8;

    // Input item codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_WEIGHT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic               take_value;   // capture weight on input transfer
        logic               vec_wr;       // write vector element
        logic [DIM_W-1:0]   vec_addr;     // vector store address (write or read)
        logic [DIM_W-1:0]   sum_addr;     // column sum address (write or read)
        logic               sum_wr;       // write back column sum
        logic               sums_clear;   // invalidate all column sums
        logic               row_clear;    // zero the row accumulator
        logic               acc;          // accumulate step
        logic               row_end;      // this step closes a row
        logic               transpose;    // transpose mode
        logic               out_load;     // load output register
        logic               out_from_col; // output from column sum, else new sum
        logic [INDEX_W-1:0] out_index;
        logic               out_last;
    } t_mvm_cmd;

endpackage

`default_nettype wire

// ===== design/matrix_vector_multiply_unit.sv =====
// Matrix-vector multiply unit, top level: controller plus datapath.
// Depends on mvm_pkg, mvm_ctrl and mvm_datapath.
//
// Usage: program row_count, column_count and transpose_mode on the config
// channel (one transfer per write, always ready; any write restarts the
// matrix). Then send the vector (func 0) one element per transfer, followed
// by the row-major matrix (func 1) one weight per transfer.
// Normal mode returns one Q8.8 result at the end of each row; transpose mode
// returns column_count results, index 0 upward, after the last weight.
// Sequencing: a vector element is stored while the unit stays idle. A
// weight passes capture, memory read, multiply register and accumulate
// (single multiply-accumulate path) before the next item is taken; a row
// end in normal mode adds an emit step to load the output register. The
// transpose drain reads the column sum memory once per result.
// Results sit in an output register; input ready stays high while a result
// waits, until another result must be loaded, then the unit holds.
// Reset (synchronous, active low) sets 1 row, 1 column, normal mode, clears
// positions, the row sum and the column-sum valid bits; the vector store
// is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_multiply_unit
    import mvm_pkg::*;
#(
    parameter int MAX_DIM   = MVM_MAX_DIM,
    parameter int ACC_WIDTH = MVM_ACC_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration writes
    input  wire logic                      i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    output logic                           o_cfg_ready,
    // input items
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_func,
    input  wire logic signed [VALUE_W-1:0] i_value,
    // result items
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed [VALUE_W-1:0]      o_result,
    output logic [INDEX_W-1:0]             o_result_index,
    output logic                           o_saturated,
    output logic                           o_last
);

    t_mvm_cmd cmd;

    // sequencing, counters and config registers
    mvm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // memories, MAC and output payload register
    mvm_datapath #(
        .MAX_DIM   (MAX_DIM),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_result       (o_result),
        .o_result_index (o_result_index),
        .o_saturated    (o_saturated),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== design/mvm_ctrl.sv =====
// Controller for the matrix-vector multiply unit: configuration registers,
// position counters and the sequencing state machine. Depends on mvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mvm_ctrl
    import mvm_pkg::*;
#(
    parameter int MAX_DIM = MVM_MAX_DIM
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_func,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_mvm_cmd                   o_cmd
);

    localparam int DIM_LIMIT = (MAX_DIM < MVM_DIM_CAP) ? MAX_DIM : MVM_DIM_CAP;
    localparam int AW        = $clog2(DIM_LIMIT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_EMIT,
        S_DRAIN_RD,
        S_DRAIN_WR
    } t_state;

    t_state           r_state;
    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic             r_transpose;
    logic [DIM_W-1:0] r_row;
    logic [DIM_W-1:0] r_col;
    logic [AW-1:0]    r_fill;
    logic [DIM_W-1:0] r_drain;
    logic [DIM_W-1:0] r_emit_idx;
    logic             r_emit_last;
    logic             r_out_valid;

    logic             cfg_fire;
    logic             in_fire;
    logic             out_free;
    logic             restart;
    logic [DIM_W-1:0] eff_row;
    logic [DIM_W-1:0] eff_col;
    logic [DIM_W-1:0] n_col;
    logic [DIM_W-1:0] n_row;
    logic             row_done;
    logic             mat_done;
    logic             drain_last;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] d;
        d = DIM_W'(v);
        if (d == '0) begin
            return DIM_W'(1);
        end else if (d > DIM_W'(DIM_LIMIT)) begin
            return DIM_W'(DIM_LIMIT);
        end
        return d;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        cfg_fire   = i_cfg_valid;
        in_fire    = i_in_valid && (r_state == S_IDLE);
        out_free   = !r_out_valid || i_out_ready;
        restart    = (r_row >= r_rows) || (r_col >= r_cols);
        eff_row    = restart ? '0 : r_row;
        eff_col    = restart ? '0 : r_col;
        n_col      = r_col + DIM_W'(1);
        n_row      = r_row + DIM_W'(1);
        row_done   = (n_col == r_cols);
        mat_done   = row_done && (n_row == r_rows);
        drain_last = (r_drain == r_cols - DIM_W'(1));
    end

    always_comb begin
        o_cmd              = '0;
        o_cmd.take_value   = in_fire && (i_func == FUNC_WEIGHT);
        o_cmd.vec_wr       = in_fire && (i_func == FUNC_LOAD);
        o_cmd.vec_addr     = o_cmd.vec_wr ? DIM_W'(r_fill) : (r_transpose ? r_row : r_col);
        o_cmd.sum_addr     = (r_state == S_DRAIN_RD || r_state == S_DRAIN_WR) ? r_drain : r_col;
        o_cmd.sum_wr       = (r_state == S_ACC) && r_transpose;
        o_cmd.sums_clear   = in_fire && (i_func == FUNC_WEIGHT) && r_transpose &&
                             (eff_row == '0) && (eff_col == '0);
        o_cmd.row_clear    = cfg_fire || (in_fire && (i_func == FUNC_WEIGHT) && restart);
        o_cmd.acc          = (r_state == S_ACC);
        o_cmd.row_end      = (r_state == S_ACC) && row_done;
        o_cmd.transpose    = r_transpose;
        o_cmd.out_load     = (r_state == S_EMIT || r_state == S_DRAIN_WR) && out_free;
        o_cmd.out_from_col = (r_state == S_DRAIN_WR);
        o_cmd.out_index    = (r_state == S_DRAIN_WR) ? r_drain[INDEX_W-1:0]
                                                     : r_emit_idx[INDEX_W-1:0];
        o_cmd.out_last     = (r_state == S_DRAIN_WR) ? drain_last : r_emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= DIM_W'(1);
            r_cols      <= DIM_W'(1);
            r_transpose <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_fill      <= '0;
            r_drain     <= '0;
            r_emit_idx  <= '0;
            r_emit_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_func == FUNC_LOAD) begin
                            r_fill <= (r_fill == AW'(DIM_LIMIT - 1)) ? '0 : r_fill + AW'(1);
                        end else begin
                            r_fill  <= '0;
                            r_row   <= eff_row;
                            r_col   <= eff_col;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (row_done) begin
                        r_col       <= '0;
                        r_emit_idx  <= r_row;
                        r_emit_last <= (n_row == r_rows);
                        r_row       <= (n_row == r_rows) ? '0 : n_row;
                        r_drain     <= '0;
                        if (!r_transpose) begin
                            r_state <= S_EMIT;
                        end else if (mat_done) begin
                            r_state <= S_DRAIN_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_col   <= n_col;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DRAIN_RD: begin
                    r_state <= S_DRAIN_WR;
                end
                S_DRAIN_WR: begin
                    if (out_free) begin
                        if (drain_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_drain <= r_drain + DIM_W'(1);
                            r_state <= S_DRAIN_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // any write, valid index or not, restarts the matrix
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    CFG_ROWS:      r_rows      <= clamp_dim(i_cfg_data);
                    CFG_COLS:      r_cols      <= clamp_dim(i_cfg_data);
                    CFG_TRANSPOSE: r_transpose <= i_cfg_data[0];
                    default: begin
                    end
                endcase
                r_row <= '0;
                r_col <= '0;
            end
        end
    end

`ifndef SYNTH
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_row < r_rows) && (r_col < r_cols))
        else $error("position counter outside matrix while busy");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EMIT || r_state == S_DRAIN_WR))
        else $error("output valid raised outside an emit state");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= AW'(DIM_LIMIT - 1))
        else $error("vector fill pointer past store depth");

    a_drain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN_RD || r_state == S_DRAIN_WR) |-> (r_drain < DIM_W'(DIM_LIMIT)))
        else $error("drain index past column store depth");
`endif

endmodule

`default_nettype wire

// ===== design/mvm_datapath.sv =====
// Datapath for the matrix-vector multiply unit: vector and column-sum memories,
// multiplier, saturating accumulator and output register. Depends on mvm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mvm_datapath
    import mvm_pkg::*;
#(
    parameter int MAX_DIM   = MVM_MAX_DIM,
    parameter int ACC_WIDTH = MVM_ACC_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire t_mvm_cmd                  i_cmd,
    output logic signed [VALUE_W-1:0]      o_result,
    output logic [INDEX_W-1:0]             o_result_index,
    output logic                           o_saturated,
    output logic                           o_last
);

    localparam int DIM_LIMIT = (MAX_DIM < MVM_DIM_CAP) ? MAX_DIM : MVM_DIM_CAP;
    localparam int AW        = $clog2(DIM_LIMIT);
    localparam int PROD_W    = 2 * VALUE_W;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX  = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN  = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [ACC_WIDTH-1:0] SAT_HI   = ACC_WIDTH'(MVM_SAT_HI);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO   = ACC_WIDTH'(MVM_SAT_LO);
    localparam logic signed [ACC_WIDTH-1:0] RND_BIAS = ACC_WIDTH'(MVM_RND_BIAS);

    logic signed [VALUE_W-1:0]   r_vec_mem [DIM_LIMIT];
    logic signed [ACC_WIDTH-1:0] r_sum_mem [DIM_LIMIT];
    logic [DIM_LIMIT-1:0]        r_sum_vld;

    logic signed [VALUE_W-1:0]   r_vec_q;
    logic signed [ACC_WIDTH-1:0] r_csum_q;
    logic                        r_csum_vld_q;
    logic signed [VALUE_W-1:0]   r_value;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_WIDTH-1:0] r_row_sum;
    logic signed [ACC_WIDTH-1:0] r_new_sum;
    logic signed [VALUE_W-1:0]   r_result;
    logic [INDEX_W-1:0]          r_index;
    logic                        r_sat;
    logic                        r_last;

    logic signed [ACC_WIDTH-1:0] csum_eff;
    logic signed [ACC_WIDTH-1:0] base;
    logic signed [ACC_WIDTH:0]   sum_wide;
    logic signed [ACC_WIDTH-1:0] n_sum;
    logic signed [ACC_WIDTH-1:0] conv_src;
    logic signed [ACC_WIDTH-1:0] rounded;
    logic signed [ACC_WIDTH-1:0] shifted;
    logic signed [VALUE_W-1:0]   n_result;
    logic                        n_sat;

    // vector store: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.vec_wr) begin
            r_vec_mem[i_cmd.vec_addr[AW-1:0]] <= i_value;
        end
        r_vec_q <= r_vec_mem[i_cmd.vec_addr[AW-1:0]];
    end

    // column sums: entries not valid read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_wr) begin
            r_sum_mem[i_cmd.sum_addr[AW-1:0]] <= n_sum;
        end
        r_csum_q     <= r_sum_mem[i_cmd.sum_addr[AW-1:0]];
        r_csum_vld_q <= r_sum_vld[i_cmd.sum_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
            r_row_sum <= '0;
        end else begin
            if (i_cmd.sums_clear) begin
                r_sum_vld <= '0;
            end else if (i_cmd.sum_wr) begin
                r_sum_vld[i_cmd.sum_addr[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.row_clear) begin
                r_row_sum <= '0;
            end else if (i_cmd.acc && !i_cmd.transpose) begin
                r_row_sum <= i_cmd.row_end ? '0 : n_sum;
            end
        end
    end

    always_comb begin
        csum_eff = r_csum_vld_q ? r_csum_q : '0;
        base     = i_cmd.transpose ? csum_eff : r_row_sum;
        sum_wide = (ACC_WIDTH+1)'(base) + (ACC_WIDTH+1)'(r_prod);
        // clamp at the accumulator limits
        if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1]) begin
            n_sum = sum_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            n_sum = sum_wide[ACC_WIDTH-1:0];
        end
    end

    // Q16.16 to Q8.8: round half up, clamp to 16 bits
    always_comb begin
        conv_src = i_cmd.out_from_col ? csum_eff : r_new_sum;
        rounded  = conv_src + RND_BIAS;
        shifted  = rounded >>> MVM_FRAC_DROP;
        if (conv_src >= SAT_HI) begin
            n_result = {1'b0, {(VALUE_W-1){1'b1}}};
            n_sat    = 1'b1;
        end else if (conv_src < SAT_LO) begin
            n_result = {1'b1, {(VALUE_W-1){1'b0}}};
            n_sat    = 1'b1;
        end else begin
            n_result = shifted[VALUE_W-1:0];
            n_sat    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_value) begin
            r_value <= i_value;
        end
        r_prod <= r_value * r_vec_q;
        if (i_cmd.acc) begin
            r_new_sum <= n_sum;
        end
        if (i_cmd.out_load) begin
            r_result <= n_result;
            r_sat    <= n_sat;
            r_index  <= i_cmd.out_index;
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_result       = r_result;
    assign o_result_index = r_index;
    assign o_saturated    = r_sat;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// ===== bench/matrix_vector_multiply_unit_tb.sv =====
// Self-checking bench for matrix_vector_multiply_unit: directed corner cases, then random
// matrix jobs in both modes. Depends on mvm_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module matrix_vector_multiply_unit_tb;
    import mvm_pkg::*;

    localparam int ACC_W        = MVM_ACC_WIDTH;
    localparam int DIM_LIM      = (MVM_MAX_DIM < MVM_DIM_CAP) ? MVM_MAX_DIM : MVM_DIM_CAP;
    localparam int SETTLE       = 10;    // cycles for a weight still in flight
    localparam int HOLD_CYCLES  = 300;   // long output stall to back up the input
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;   // no register here

    typedef struct {
        logic signed [VALUE_W-1:0] result;
        logic [INDEX_W-1:0]        index;
        logic                      saturated;
        logic                      last;
    } t_mvm_result;

    // Tracks the unit's state and holds the outputs still owed, oldest first.
    class mvm_scoreboard;
        logic [DIM_W-1:0]          rows_cfg;
        logic [DIM_W-1:0]          cols_cfg;
        logic                      transpose_cfg;
        logic signed [VALUE_W-1:0] vec_mem [MVM_DIM_CAP];
        longint                    col_acc [MVM_DIM_CAP];
        longint                    row_acc;
        int unsigned               row_pos;
        int unsigned               col_pos;
        int unsigned               fill;
        t_mvm_result               expected_q [$];
        int                        errors;
        int                        inputs_seen;
        int                        results_seen;

        function new();
            rows_cfg      = 1;
            cols_cfg      = 1;
            transpose_cfg = 1'b0;
            foreach (vec_mem[i]) vec_mem[i] = '0;
            foreach (col_acc[i]) col_acc[i] = 0;
            fill          = 0;
            errors        = 0;
            inputs_seen   = 0;
            results_seen  = 0;
            restart();
        endfunction

        function int unsigned span(logic [DIM_W-1:0] d);
            if (d == 0) return 1;
            if (d > DIM_LIM) return DIM_LIM;
            return d;
        endfunction

        function void restart();
            row_acc = 0;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function longint sat_add(longint a, longint p);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (ACC_W - 1)) - 1;
            lo = -hi - 1;
            if (p > 0 && a > hi - p) return hi;
            if (p < 0 && a < lo - p) return lo;
            return a + p;
        endfunction

        // Q16.16 sum -> Q8.8, round half up, clamp to 16 bits
        function void push_result(longint acc, int unsigned idx, bit is_last);
            t_mvm_result e;
            longint q;
            e.saturated = 1'b0;
            if (acc >= longint'(MVM_SAT_HI)) begin
                q = 32767;
                e.saturated = 1'b1;
            end else if (acc < longint'(MVM_SAT_LO)) begin
                q = -32768;
                e.saturated = 1'b1;
            end else begin
                q = (acc + MVM_RND_BIAS) >>> MVM_FRAC_DROP;
            end
            e.result = q[VALUE_W-1:0];
            e.index  = idx[INDEX_W-1:0];
            e.last   = is_last;
            expected_q.push_back(e);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROWS:      rows_cfg = data;
                CFG_COLS:      cols_cfg = data;
                CFG_TRANSPOSE: transpose_cfg = data[0];
                default:       ;
            endcase
            restart();   // any write, spare index included
        endfunction

        function void note_input(logic f, logic signed [VALUE_W-1:0] v);
            int unsigned nr;
            int unsigned nc;
            longint prod;
            nr = span(rows_cfg);
            nc = span(cols_cfg);
            inputs_seen++;
            if (f == FUNC_LOAD) begin
                if (fill >= DIM_LIM) fill = 0;
                vec_mem[fill] = v;
                fill++;
                if (fill >= DIM_LIM) fill = 0;
                return;
            end
            fill = 0;   // the next load starts a fresh vector
            if (row_pos >= nr || col_pos >= nc) restart();
            if (!transpose_cfg) begin
                prod = longint'(v) * longint'(vec_mem[col_pos]);
                row_acc = sat_add(row_acc, prod);
                col_pos++;
                if (col_pos == nc) begin
                    push_result(row_acc, row_pos, row_pos == nr - 1);
                    row_acc = 0;
                    col_pos = 0;
                    row_pos++;
                    if (row_pos == nr) row_pos = 0;
                end
            end else begin
                if (row_pos == 0 && col_pos == 0)
                    foreach (col_acc[i]) col_acc[i] = 0;
                prod = longint'(v) * longint'(vec_mem[row_pos]);
                col_acc[col_pos] = sat_add(col_acc[col_pos], prod);
                col_pos++;
                if (col_pos == nc) begin
                    col_pos = 0;
                    row_pos++;
                    if (row_pos == nr) begin
                        row_pos = 0;
                        for (int c = 0; c < nc; c++)
                            push_result(col_acc[c], c, c == nc - 1);
                    end
                end
            end
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] r, logic [INDEX_W-1:0] idx,
                                   logic sat, logic lst);
            t_mvm_result e;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result %0d at index %0d, nothing pending", r, idx);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (r !== e.result) begin
                $error("result: expected %0d, got %0d", e.result, r);
                errors++;
            end
            if (idx !== e.index) begin
                $error("result_index: expected %0d, got %0d", e.index, idx);
                errors++;
            end
            if (sat !== e.saturated) begin
                $error("saturated: expected %0b, got %0b", e.saturated, sat);
                errors++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0b, got %0b", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      o_cfg_ready;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_func;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [VALUE_W-1:0] o_result;
    logic [INDEX_W-1:0]        o_result_index;
    logic                      o_saturated;
    logic                      o_last;

    mvm_scoreboard sb = new();
    bit            hold_request = 1'b0;   // asks the result side for a long stall

    matrix_vector_multiply_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (o_result),
        .o_result_index (o_result_index),
        .o_saturated    (o_saturated),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Transfer monitor. Reads pre-edge values, so it sees exactly what the unit
    // sampled. Results are checked before new inputs add expectations.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_result, o_result_index, o_saturated, o_last);
            if (i_cfg_valid && o_cfg_ready)
                sb.note_config(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_input(i_func, i_value);
        end
    end

    // Result side: random ready with a quiet stretch, plus one long stall on
    // request while the sender keeps pushing.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (sb.results_seen >= 30 && sb.results_seen < 80) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Mostly small Q8.8 values so sums stay in range; some full-range ones.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int s;
        if ($urandom_range(9) < 7) begin
            s = int'($urandom_range(2047)) - 1024;
            return VALUE_W'(s);
        end
        return VALUE_W'($urandom());
    endfunction

    // One input transfer. Valid stays up across back-to-back items and only
    // drops for a random gap or at a drain.
    task automatic send_item(input logic f, input logic signed [VALUE_W-1:0] v);
        int gap_pct;
        gap_pct = (sb.inputs_seen >= 40 && sb.inputs_seen < 100) ? 0 : 15;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop sending, collect everything owed, then let any result-less weight
    // finish inside the unit.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [DIM_W-1:0] rows_data, input logic [DIM_W-1:0] cols_data,
                               input logic tr, input bit spare_too);
        drain();
        cfg_write(CFG_ROWS, rows_data);
        cfg_write(CFG_TRANSPOSE, {6'($urandom()), tr});   // only bit 0 matters
        cfg_write(CFG_COLS, cols_data);
        if (spare_too) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom()));
        cfg_release();
    endtask

    // One setting, several matrices. Every vector entry the matrix reads is
    // loaded first; stray loads between weights only rewrite the low entries.
    task automatic run_phase(input logic [DIM_W-1:0] rows_data, input logic [DIM_W-1:0] cols_data,
                             input logic tr, input int jobs, input bit squeeze_out);
        int unsigned nr;
        int unsigned nc;
        int unsigned need;
        reconfigure(rows_data, cols_data, tr, $urandom_range(3) == 0);
        nr   = sb.span(rows_data);
        nc   = sb.span(cols_data);
        need = tr ? nr : nc;
        for (int k = 0; k < jobs; k++) begin
            repeat (need + $urandom_range(0, 2)) send_item(FUNC_LOAD, pick_value());
            if (squeeze_out && k == 0) hold_request = 1'b1;
            for (int i = 0; i < nr * nc; i++) begin
                if (i > 0 && $urandom_range(99) < 8)
                    repeat ($urandom_range(1, 2)) send_item(FUNC_LOAD, pick_value());
                send_item(FUNC_WEIGHT, pick_value());
            end
        end
        // now and then leave a matrix half done; the next write restarts it
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_item(FUNC_WEIGHT, pick_value());
    endtask

    initial begin
        int start_count;
        logic [DIM_W-1:0] rd;
        logic [DIM_W-1:0] cd;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_func      <= FUNC_LOAD;
        i_value     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting, 1x1 normal mode: rounding ties and both clamps.
        send_item(FUNC_LOAD, 16'sh0001);
        send_item(FUNC_WEIGHT, 16'sh0080);    // half LSB up -> 1
        send_item(FUNC_WEIGHT, -16'sh0080);   // minus half LSB -> 0
        send_item(FUNC_WEIGHT, -16'sh0180);   // -1.5 LSB -> -1
        send_item(FUNC_WEIGHT, 16'sh7fff);
        send_item(FUNC_WEIGHT, 16'sh8000);
        send_item(FUNC_LOAD, 16'sh0101);
        send_item(FUNC_WEIGHT, 16'sh7f80);    // sum lands exactly on the high clamp
        send_item(FUNC_LOAD, 16'sh7fff);
        send_item(FUNC_WEIGHT, 16'sh7fff);    // far above range
        send_item(FUNC_WEIGHT, 16'sh8000);    // far below range
        send_item(FUNC_LOAD, 16'sh8000);
        send_item(FUNC_WEIGHT, 16'sh8000);    // most negative squared

        // 2x3 normal: abandon a matrix midway via a spare-index write.
        reconfigure(7'd2, 7'd3, 1'b0, 1'b0);
        repeat (3) send_item(FUNC_LOAD, pick_value());
        repeat (2) send_item(FUNC_WEIGHT, pick_value());
        drain();
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom()));
        cfg_release();
        repeat (6) send_item(FUNC_WEIGHT, pick_value());

        // Output stalled on a row-per-weight job, so results back up and the
        // input holds.
        run_phase(7'd8, 7'd1, 1'b0, 1, 1'b1);

        // Size extremes in transpose mode: row count clamped from 0, column
        // count clamped from 127, full-width drain.
        run_phase(7'd0, 7'd127, 1'b1, 1, 1'b0);

        // Random small settings.
        start_count = sb.inputs_seen;
        while (sb.inputs_seen - start_count < 12) begin
            rd = ($urandom_range(9) == 0) ? 7'd0 : DIM_W'($urandom_range(1, 4));
            cd = ($urandom_range(9) == 0) ? 7'd0 : DIM_W'($urandom_range(1, 4));
            run_phase(rd, cd, 1'($urandom_range(1)), $urandom_range(1, 3), 1'b0);
        end

        drain();
        if (sb.expected_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
